>>> hdl/hiss_pkg.sv
// Shared types and constants of the image header size sniffer.
package hiss_pkg;

  // Byte offset counter width
  localparam int unsigned OFFSET_BITS = 32;

  // Image format codes
  localparam logic [2:0] FMT_NONE     = 3'd0;
  localparam logic [2:0] FMT_PNG      = 3'd1;
  localparam logic [2:0] FMT_JPEG     = 3'd2;
  localparam logic [2:0] FMT_WEBP_VP8 = 3'd3;
  localparam logic [2:0] FMT_WEBP_VP8L = 3'd4;
  localparam logic [2:0] FMT_WEBP_VP8X = 3'd5;

  // Four-byte tags, first byte in the high byte
  localparam logic [31:0] TAG_PNG  = 32'h8950_4E47;
  localparam logic [31:0] TAG_IHDR = 32'h4948_4452;
  localparam logic [31:0] TAG_CGBI = 32'h4367_4249;
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WEBP = 32'h5745_4250;
  localparam logic [31:0] TAG_VP8  = 32'h5650_3820;
  localparam logic [31:0] TAG_VP8L = 32'h5650_384C;
  localparam logic [31:0] TAG_VP8X = 32'h5650_3858;

  // Input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } hiss_in_t;

  // Result word
  typedef struct packed {
    logic [2:0]  image_format;
    logic [31:0] image_width;
    logic [31:0] image_height;
  } hiss_out_t;

  // Per-byte control and data handed to each recognizer
  typedef struct packed {
    logic                   run;   // byte accepted, nothing found yet
    logic                   clr;   // byte accepted and it is the last one
    logic [OFFSET_BITS-1:0] off;   // offset of this byte
    logic [7:0]             b;     // this byte
    logic [31:0]            s;     // last four bytes, newest low
  } hiss_step_t;

  // What a recognizer reports for this byte
  typedef struct packed {
    logic        set_w;
    logic        set_h;
    logic        done;
    logic [2:0]  fmt;
    logic [31:0] w;
    logic [31:0] h;
  } hiss_hit_t;

endpackage

>>> hdl/image_header_size_sniffer.sv
// Top level of the image header size sniffer.
//
// Usage: feed the bytes of one image file on the input channel, one byte per
// word, offset zero first, with last_byte set on the final byte. PNG, JPEG
// and WebP recognizers inspect every byte in parallel. When the last byte is
// accepted, one result word (format, width, height) is produced; every other
// byte produces none, and all parsing state clears for the next file.
// A file with no recognized header, or a WebP file while webp_enable is 0,
// gives format 0 and zero size.
// Latency: the result is valid in the cycle after the last byte is accepted.
// Throughput: one byte per cycle while in_stall_o is low; each byte passes through one level of
// compare logic into the recognizer state and the output register.
// Stalls: the result sits in the output register while out_stall_i is high;
// input is stalled only while that register is full and stalled.
// Reset: clears all parsing state and the output register; webp_enable
// resets to 1. cfg_we_i writes webp_enable from cfg_wdata_i.
module image_header_size_sniffer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hiss_pkg::hiss_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hiss_pkg::hiss_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i
);

  localparam int unsigned OB = hiss_pkg::OFFSET_BITS;

  logic                webp_en_q;
  logic [OB-1:0]       off_q;
  logic [31:0]         shift_q, shift_d;
  logic [2:0]          fmt_q, fmt_d;
  logic [31:0]         w_q, w_d;
  logic [31:0]         h_q, h_d;
  logic                accept;
  logic [2:0]          res_fmt;
  logic                out_valid_q;
  hiss_pkg::hiss_out_t out_q;
  hiss_pkg::hiss_step_t step;
  hiss_pkg::hiss_hit_t  png_hit, jpeg_hit, webp_hit;

  // Handshake: the output register decouples the two sides
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign shift_d = {shift_q[23:0], in_data_i.data_byte};

  assign step.run = accept && (fmt_q == hiss_pkg::FMT_NONE);
  assign step.clr = accept && in_data_i.last_byte;
  assign step.off = off_q;
  assign step.b   = in_data_i.data_byte;
  assign step.s   = shift_d;

  hiss_png u_png (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .hit_o  (png_hit)
  );

  hiss_jpeg u_jpeg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .hit_o  (jpeg_hit)
  );

  hiss_webp u_webp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .hit_o  (webp_hit)
  );

  // Found size update; later recognizers override earlier ones as in order
  always_comb begin
    fmt_d = fmt_q;
    w_d   = w_q;
    h_d   = h_q;
    if (step.run) begin
      if (png_hit.set_w) w_d = png_hit.w;
      if (png_hit.set_h) h_d = png_hit.h;
      if (png_hit.done) fmt_d = png_hit.fmt;
      if (jpeg_hit.set_w) w_d = jpeg_hit.w;
      if (jpeg_hit.set_h) h_d = jpeg_hit.h;
      if (jpeg_hit.done) fmt_d = jpeg_hit.fmt;
      if (webp_hit.set_w) w_d = webp_hit.w;
      if (webp_hit.set_h) h_d = webp_hit.h;
      if (webp_hit.done) fmt_d = webp_hit.fmt;
    end
  end

  // Result format: WebP masked by the enable, unknown codes as none
  always_comb begin
    res_fmt = fmt_d;
    if (fmt_d >= hiss_pkg::FMT_WEBP_VP8 && !webp_en_q) res_fmt = hiss_pkg::FMT_NONE;
    if (fmt_d > hiss_pkg::FMT_WEBP_VP8X) res_fmt = hiss_pkg::FMT_NONE;
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      webp_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      webp_en_q <= cfg_wdata_i;
    end
  end

  // Stream state: offset, shift word, found header
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q   <= '0;
      shift_q <= '0;
      fmt_q   <= hiss_pkg::FMT_NONE;
      w_q     <= '0;
      h_q     <= '0;
    end else if (step.clr) begin
      off_q   <= '0;
      shift_q <= '0;
      fmt_q   <= hiss_pkg::FMT_NONE;
      w_q     <= '0;
      h_q     <= '0;
    end else if (accept) begin
      if (off_q != {OB{1'b1}}) off_q <= off_q + OB'(1);
      shift_q <= shift_d;
      fmt_q   <= fmt_d;
      w_q     <= w_d;
      h_q     <= h_d;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step.clr) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (step.clr) begin
      out_q.image_format <= res_fmt;
      out_q.image_width  <= (res_fmt == hiss_pkg::FMT_NONE) ? 32'd0 : w_d;
      out_q.image_height <= (res_fmt == hiss_pkg::FMT_NONE) ? 32'd0 : h_d;
    end
  end

endmodule

>>> hdl/hiss_png.sv
// PNG recognizer: plain IHDR and the CgBI variant, big-endian size.
module hiss_png (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hiss_pkg::hiss_step_t step_i,
  output hiss_pkg::hiss_hit_t  hit_o
);

  localparam logic [3:0] P_SIG   = 4'd0;
  localparam logic [3:0] P_WAIT  = 4'd1;
  localparam logic [3:0] P_IHDR  = 4'd2;
  localparam logic [3:0] P_CGBI  = 4'd3;
  localparam logic [3:0] P_CIHDR = 4'd4;
  localparam logic [3:0] P_DONE  = 4'd5;
  localparam logic [3:0] P_DEAD  = 4'd6;

  localparam int unsigned OB = hiss_pkg::OFFSET_BITS;

  logic [3:0] phase_q, phase_d;

  // Next phase and size capture
  always_comb begin
    phase_d = phase_q;
    hit_o   = '0;
    hit_o.fmt = hiss_pkg::FMT_PNG;
    hit_o.w   = step_i.s;
    hit_o.h   = step_i.s;
    case (phase_q)
      P_SIG: begin
        if (step_i.off == OB'(3)) begin
          phase_d = (step_i.s == hiss_pkg::TAG_PNG) ? P_WAIT : P_DEAD;
        end
      end
      P_WAIT: begin
        if (step_i.off == OB'(15)) begin
          if (step_i.s == hiss_pkg::TAG_IHDR) phase_d = P_IHDR;
          else if (step_i.s == hiss_pkg::TAG_CGBI) phase_d = P_CGBI;
          else phase_d = P_DEAD;
        end
      end
      P_IHDR: begin
        hit_o.set_w = (step_i.off == OB'(19));
        if (step_i.off == OB'(23)) begin
          hit_o.set_h = 1'b1;
          hit_o.done  = 1'b1;
          phase_d     = P_DONE;
        end
      end
      P_CGBI: begin
        if (step_i.off == OB'(31)) begin
          phase_d = (step_i.s == hiss_pkg::TAG_IHDR) ? P_CIHDR : P_DEAD;
        end
      end
      P_CIHDR: begin
        hit_o.set_w = (step_i.off == OB'(35));
        if (step_i.off == OB'(39)) begin
          hit_o.set_h = 1'b1;
          hit_o.done  = 1'b1;
          phase_d     = P_DONE;
        end
      end
      default: ;
    endcase
  end

  // Phase register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_SIG;
    end else if (step_i.clr) begin
      phase_q <= P_SIG;
    end else if (step_i.run) begin
      phase_q <= phase_d;
    end
  end

endmodule

>>> hdl/hiss_jpeg.sv
// JPEG recognizer: walks segments after SOI up to a SOF0/1/2 marker.
module hiss_jpeg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hiss_pkg::hiss_step_t step_i,
  output hiss_pkg::hiss_hit_t  hit_o
);

  localparam logic [3:0] J_SOI0  = 4'd0;
  localparam logic [3:0] J_SOI1  = 4'd1;
  localparam logic [3:0] J_MK0   = 4'd2;
  localparam logic [3:0] J_MK1FF = 4'd3;
  localparam logic [3:0] J_MK1   = 4'd4;
  localparam logic [3:0] J_LEN0  = 4'd5;
  localparam logic [3:0] J_LEN1  = 4'd6;
  localparam logic [3:0] J_SKIP  = 4'd7;
  localparam logic [3:0] J_PAD   = 4'd8;
  localparam logic [3:0] J_H0    = 4'd9;
  localparam logic [3:0] J_H1    = 4'd10;
  localparam logic [3:0] J_W0    = 4'd11;
  localparam logic [3:0] J_W1    = 4'd12;
  localparam logic [3:0] J_DONE  = 4'd13;
  localparam logic [3:0] J_DEAD  = 4'd14;

  logic [3:0]  phase_q, phase_d;
  logic [15:0] skip_q, skip_d;
  logic [15:0] skip_dec;
  logic [15:0] seg_len;

  assign skip_dec = skip_q - 16'd1;
  assign seg_len  = step_i.s[15:0];

  // Next phase, skip count and size capture
  always_comb begin
    phase_d   = phase_q;
    skip_d    = skip_q;
    hit_o     = '0;
    hit_o.fmt = hiss_pkg::FMT_JPEG;
    hit_o.w   = {16'd0, step_i.s[15:0]};
    hit_o.h   = {16'd0, step_i.s[15:0]};
    case (phase_q)
      J_SOI0: phase_d = (step_i.b == 8'hFF) ? J_SOI1 : J_DEAD;
      J_SOI1: phase_d = (step_i.b == 8'hD8) ? J_MK0 : J_DEAD;
      J_MK0:  phase_d = (step_i.b == 8'hFF) ? J_MK1FF : J_MK1;
      J_MK1FF: begin
        if (step_i.b inside {[8'hC0:8'hC2]}) begin
          skip_d  = 16'd3;
          phase_d = J_PAD;
        end else begin
          phase_d = J_LEN0;
        end
      end
      J_MK1:  phase_d = J_LEN0;
      J_LEN0: phase_d = J_LEN1;
      J_LEN1: begin
        // lengths below 2 are malformed
        if (seg_len < 16'd2) begin
          phase_d = J_DEAD;
        end else if (seg_len == 16'd2) begin
          phase_d = J_MK0;
        end else begin
          skip_d  = seg_len - 16'd2;
          phase_d = J_SKIP;
        end
      end
      J_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == 16'd0) phase_d = J_MK0;
      end
      J_PAD: begin
        skip_d = skip_dec;
        if (skip_dec == 16'd0) phase_d = J_H0;
      end
      J_H0: phase_d = J_H1;
      J_H1: begin
        hit_o.set_h = 1'b1;
        phase_d     = J_W0;
      end
      J_W0: phase_d = J_W1;
      J_W1: begin
        hit_o.set_w = 1'b1;
        hit_o.done  = 1'b1;
        phase_d     = J_DONE;
      end
      default: ;
    endcase
  end

  // Phase and skip registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= J_SOI0;
      skip_q  <= 16'd0;
    end else if (step_i.clr) begin
      phase_q <= J_SOI0;
      skip_q  <= 16'd0;
    end else if (step_i.run) begin
      phase_q <= phase_d;
      skip_q  <= skip_d;
    end
  end

endmodule

>>> hdl/hiss_webp.sv
// WebP recognizer: VP8, VP8L and VP8X headers, little-endian size.
module hiss_webp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hiss_pkg::hiss_step_t step_i,
  output hiss_pkg::hiss_hit_t  hit_o
);

  localparam logic [3:0] W_RIFF     = 4'd0;
  localparam logic [3:0] W_TAG      = 4'd1;
  localparam logic [3:0] W_TYPE     = 4'd2;
  localparam logic [3:0] W_LOSSY    = 4'd3;
  localparam logic [3:0] W_LOSSLESS = 4'd4;
  localparam logic [3:0] W_EXT      = 4'd5;
  localparam logic [3:0] W_DONE     = 4'd6;
  localparam logic [3:0] W_DEAD     = 4'd7;

  localparam int unsigned OB = hiss_pkg::OFFSET_BITS;

  logic [3:0]  phase_q, phase_d;
  logic [31:0] le16, le24, le32;

  // Byte-swapped views of the shift word
  assign le16 = {16'd0, step_i.s[7:0], step_i.s[15:8]};
  assign le24 = {8'd0, step_i.s[7:0], step_i.s[15:8], step_i.s[23:16]};
  assign le32 = {step_i.s[7:0], step_i.s[15:8], step_i.s[23:16], step_i.s[31:24]};

  // Next phase and size capture
  always_comb begin
    phase_d = phase_q;
    hit_o   = '0;
    case (phase_q)
      W_RIFF: begin
        if (step_i.off == OB'(3)) begin
          phase_d = (step_i.s == hiss_pkg::TAG_RIFF) ? W_TAG : W_DEAD;
        end
      end
      W_TAG: begin
        if (step_i.off == OB'(11)) begin
          phase_d = (step_i.s == hiss_pkg::TAG_WEBP) ? W_TYPE : W_DEAD;
        end
      end
      W_TYPE: begin
        if (step_i.off == OB'(15)) begin
          if (step_i.s == hiss_pkg::TAG_VP8) phase_d = W_LOSSY;
          else if (step_i.s == hiss_pkg::TAG_VP8L) phase_d = W_LOSSLESS;
          else if (step_i.s == hiss_pkg::TAG_VP8X) phase_d = W_EXT;
          else phase_d = W_DEAD;
        end
      end
      W_LOSSY: begin
        hit_o.fmt   = hiss_pkg::FMT_WEBP_VP8;
        hit_o.w     = {18'd0, le16[13:0]};
        hit_o.h     = {18'd0, le16[13:0]};
        hit_o.set_w = (step_i.off == OB'(27));
        if (step_i.off == OB'(29)) begin
          hit_o.set_h = 1'b1;
          hit_o.done  = 1'b1;
          phase_d     = W_DONE;
        end
      end
      W_LOSSLESS: begin
        // 14-bit width minus one, then 14-bit height minus one
        hit_o.fmt = hiss_pkg::FMT_WEBP_VP8L;
        hit_o.w   = {18'd0, le32[13:0]} + 32'd1;
        hit_o.h   = {18'd0, le32[27:14]} + 32'd1;
        if (step_i.off == OB'(24)) begin
          hit_o.set_w = 1'b1;
          hit_o.set_h = 1'b1;
          hit_o.done  = 1'b1;
          phase_d     = W_DONE;
        end
      end
      W_EXT: begin
        hit_o.fmt = hiss_pkg::FMT_WEBP_VP8X;
        hit_o.w   = le24 + 32'd1;
        hit_o.h   = le24 + 32'd1;
        // reserved flag bits set: reject
        if (step_i.off == OB'(20) &&
            ((step_i.s[7:6] != 2'b00) || step_i.s[0])) begin
          phase_d = W_DEAD;
        end
        hit_o.set_w = (step_i.off == OB'(26));
        if (step_i.off == OB'(29)) begin
          hit_o.set_h = 1'b1;
          hit_o.done  = 1'b1;
          phase_d     = W_DONE;
        end
      end
      default: ;
    endcase
  end

  // Phase register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= W_RIFF;
    end else if (step_i.clr) begin
      phase_q <= W_RIFF;
    end else if (step_i.run) begin
      phase_q <= phase_d;
    end
  end

endmodule
